[sv/hsl2rgb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared fixed-point formats, constants and helpers of the HSL to RGB
// colour converter.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

    // Number of fraction bits of the internal unsigned fixed-point format.
    localparam int FRAC_BITS = 16;

    // A fraction in 0..1 inclusive needs one integer bit.
    localparam int FX_W  = FRAC_BITS + 1;
    // Ramp multiplier factor (six times a fraction).
    localparam int FAC_W = FRAC_BITS + 3;
    // Ramp result before conversion to a byte.
    localparam int COL_W = FRAC_BITS + 5;
    // Channel value times 255 plus rounding half.
    localparam int SCL_W = COL_W + 8;

    typedef logic [FX_W-1:0]      fx_t;
    typedef logic [FRAC_BITS-1:0] frac_t;
    typedef logic [FAC_W-1:0]     fac_t;
    typedef logic [COL_W-1:0]     col_t;

    localparam fx_t FX_ONE        = fx_t'(1) << FRAC_BITS;
    localparam fx_t FX_THIRD      = fx_t'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd3);
    localparam fx_t FX_TWO_THIRDS = fx_t'(((64'd2 << FRAC_BITS) + 64'd1) / 64'd3);
    localparam logic [SCL_W-1:0] FX_HALF = SCL_W'(64'd1 << (FRAC_BITS - 1));

    // Segment of the piecewise hue ramp.
    typedef enum logic [1:0] {
        RAMP_UP   = 2'd0,
        RAMP_HOLD = 2'd1,
        RAMP_DOWN = 2'd2,
        RAMP_LOW  = 2'd3
    } ramp_seg_t;

    // Stage load enables handed to each channel slice.
    typedef struct packed {
        logic s4;
        logic s5;
        logic s6;
    } hsl2rgb_en_t;

    // Byte to fixed-point table: round(x / 255) on the fraction grid.
    typedef fx_t fx_lut_t [256];

    function automatic fx_lut_t build_fx_lut();
        fx_lut_t          lut;
        longint unsigned  num;
        for (int i = 0; i < 256; i++) begin
            num    = (longint'(i) << FRAC_BITS) + 64'd127;
            lut[i] = fx_t'(num / 64'd255);
        end
        return lut;
    endfunction

    localparam fx_lut_t FX_LUT = build_fx_lut();

    // Brings a shifted hue back into 0..1 (exclusive of one).
    function automatic frac_t wrap_unit(logic [FX_W:0] x);
        logic [FX_W:0] y;
        y = (x >= {1'b0, FX_ONE}) ? (x - {1'b0, FX_ONE}) : x;
        return y[FRAC_BITS-1:0];
    endfunction

endpackage

[sv/hsl2rgb_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl2rgb_channel
// One colour channel: evaluates the hue ramp at a wrapped hue position and
// converts the result to a rounded, saturated byte over three stages.
// ----------------------------------------------------------------------------
module hsl2rgb_channel (
    input  logic                      clk,
    input  hsl2rgb_pkg::hsl2rgb_en_t  en,
    input  hsl2rgb_pkg::frac_t        t,
    input  hsl2rgb_pkg::fx_t          hi,
    input  hsl2rgb_pkg::fx_t          lo,
    output logic [7:0]                chan
);

    localparam int F = hsl2rgb_pkg::FRAC_BITS;

    // Stage 4 signals
    hsl2rgb_pkg::fac_t      six_t;
    hsl2rgb_pkg::fx_t       down_diff;
    hsl2rgb_pkg::fac_t      six_down;
    hsl2rgb_pkg::ramp_seg_t seg_next;
    hsl2rgb_pkg::fac_t      factor_next;
    hsl2rgb_pkg::ramp_seg_t seg_reg;
    hsl2rgb_pkg::fac_t      factor_reg;
    hsl2rgb_pkg::fx_t       span_reg;
    hsl2rgb_pkg::fx_t       hi4_reg;
    hsl2rgb_pkg::fx_t       lo4_reg;

    // Stage 5 signals
    logic [hsl2rgb_pkg::FX_W+hsl2rgb_pkg::FAC_W-1:0] ramp_prod;
    hsl2rgb_pkg::col_t      col_next;
    hsl2rgb_pkg::col_t      col_reg;

    // Stage 6 signals
    logic [hsl2rgb_pkg::SCL_W-1:0] scaled;
    logic [12:0]                   byte_wide;
    logic [7:0]                    chan_next;
    logic [7:0]                    chan_reg;

    // Stage 4: find the ramp segment and the multiplier factor.
    always_comb
    begin
        six_t     = (hsl2rgb_pkg::fac_t'(t) << 2) + (hsl2rgb_pkg::fac_t'(t) << 1);
        down_diff = hsl2rgb_pkg::FX_TWO_THIRDS - hsl2rgb_pkg::fx_t'(t);
        six_down  = (hsl2rgb_pkg::fac_t'(down_diff) << 2)
                  + (hsl2rgb_pkg::fac_t'(down_diff) << 1);
        priority if (six_t < hsl2rgb_pkg::fac_t'(hsl2rgb_pkg::FX_ONE))
        begin
            seg_next    = hsl2rgb_pkg::RAMP_UP;
            factor_next = six_t;
        end
        else if (!t[F-1])
        begin
            seg_next    = hsl2rgb_pkg::RAMP_HOLD;
            factor_next = six_down;
        end
        else if (hsl2rgb_pkg::fx_t'(t) < hsl2rgb_pkg::FX_TWO_THIRDS)
        begin
            seg_next    = hsl2rgb_pkg::RAMP_DOWN;
            factor_next = six_down;
        end
        else
        begin
            seg_next    = hsl2rgb_pkg::RAMP_LOW;
            factor_next = six_down;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            seg_reg    <= seg_next;
            factor_reg <= factor_next;
            span_reg   <= hi - lo;
            hi4_reg    <= hi;
            lo4_reg    <= lo;
        end
    end

    // Stage 5: scale the span and pick the segment value.
    always_comb
    begin
        ramp_prod = span_reg * factor_reg;
        unique case (seg_reg)
            hsl2rgb_pkg::RAMP_UP,
            hsl2rgb_pkg::RAMP_DOWN:
                col_next = hsl2rgb_pkg::col_t'(lo4_reg)
                         + hsl2rgb_pkg::col_t'(ramp_prod[F +: (hsl2rgb_pkg::FAC_W + 1)]);
            hsl2rgb_pkg::RAMP_HOLD:
                col_next = hsl2rgb_pkg::col_t'(hi4_reg);
            default:
                col_next = hsl2rgb_pkg::col_t'(lo4_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            col_reg <= col_next;
        end
    end

    // Stage 6: multiply by 255, round half up and saturate.
    always_comb
    begin
        scaled    = (hsl2rgb_pkg::SCL_W'(col_reg) << 8) - hsl2rgb_pkg::SCL_W'(col_reg)
                  + hsl2rgb_pkg::FX_HALF;
        byte_wide = scaled[F +: 13];
        chan_next = (byte_wide > 13'd255) ? 8'hFF : byte_wide[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

[sv/hsl_to_rgb_converter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_core
// Six-stage pipelined HSL to RGB colour converter.
// ----------------------------------------------------------------------------
// Usage:
// An input item is one pixel (hue, saturation, lightness, each 8 bits as a
// fraction of 255) on the s_axis channel; each item gives exactly one result
// item (red, green, blue bytes) on the m_axis channel, in order.
// m_axis_tvalid rises once the item has passed all six register stages, and
// with m_axis_tready high the result item is then taken by the receiver.
// While the receiver does not stall, the pipeline accepts one item every cycle;
// the rate is set by the six register stages, each holding one item.
// Stages: byte to fraction lookup, lightness times saturation multiply,
// bound values and hue wrap, ramp segment decode, ramp multiply, byte
// rounding into the output register.
// Each stage carries a valid bit and loads whenever it is empty or the next
// stage is loading, so gaps close up and a stalled receiver holds the items
// in place without loss. s_axis_tready stays high while any stage is empty.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // hue[7:0], saturation[15:8], lightness[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int F  = hsl2rgb_pkg::FRAC_BITS;
    localparam int FW = hsl2rgb_pkg::FX_W;

    // Pipeline control
    logic [5:0] valid_reg;
    logic [5:0] ready;
    logic [5:0] up_valid;

    // Input fields
    logic [7:0] in_hue;
    logic [7:0] in_sat;
    logic [7:0] in_lit;

    // Stage 1
    hsl2rgb_pkg::fx_t h1_reg, s1_reg, l1_reg;
    logic             zero1_reg, dark1_reg;
    logic [7:0]       lit1_reg;

    // Stage 2
    logic [2*FW-1:0]  prod_full;
    hsl2rgb_pkg::fx_t h2_reg, s2_reg, l2_reg, prod2_reg;
    logic             zero2_reg, dark2_reg;
    logic [7:0]       lit2_reg;

    // Stage 3
    logic [FW:0]        hi_raw;
    hsl2rgb_pkg::fx_t   hi_next;
    logic [FW:0]        two_l;
    logic [FW:0]        lo_raw;
    hsl2rgb_pkg::fx_t   lo_next;
    hsl2rgb_pkg::fx_t   hi3_reg, lo3_reg;
    hsl2rgb_pkg::frac_t tr3_reg, tg3_reg, tb3_reg;
    logic               zero3_reg, zero4_reg, zero5_reg, zero6_reg;
    logic [7:0]         lit3_reg, lit4_reg, lit5_reg, lit6_reg;

    // Channel slices
    hsl2rgb_pkg::hsl2rgb_en_t chan_en;
    logic [7:0]               red_byte, green_byte, blue_byte;

    assign in_hue = s_axis_tdata[7:0];
    assign in_sat = s_axis_tdata[15:8];
    assign in_lit = s_axis_tdata[23:16];

    // A stage loads when it is empty or its successor is loading.
    always_comb
    begin
        ready[5] = !valid_reg[5] || m_axis_tready;
        for (int i = 4; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        up_valid = {valid_reg[4:0], s_axis_tvalid};
    end

    assign s_axis_tready = ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < 6; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= up_valid[i];
                end
            end
        end
    end

    // Stage 1: bytes to fixed-point fractions.
    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            h1_reg    <= hsl2rgb_pkg::FX_LUT[in_hue];
            s1_reg    <= hsl2rgb_pkg::FX_LUT[in_sat];
            l1_reg    <= hsl2rgb_pkg::FX_LUT[in_lit];
            zero1_reg <= (in_sat == 8'd0);
            dark1_reg <= !in_lit[7];
            lit1_reg  <= in_lit;
        end
    end

    // Stage 2: lightness times saturation, truncated.
    assign prod_full = l1_reg * s1_reg;

    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            prod2_reg <= prod_full[F +: FW];
            h2_reg    <= h1_reg;
            s2_reg    <= s1_reg;
            l2_reg    <= l1_reg;
            zero2_reg <= zero1_reg;
            dark2_reg <= dark1_reg;
            lit2_reg  <= lit1_reg;
        end
    end

    // Stage 3: bound values, clamped, and the three wrapped hue positions.
    always_comb
    begin
        if (dark2_reg)
        begin
            hi_raw = {1'b0, l2_reg} + {1'b0, prod2_reg};
        end
        else
        begin
            hi_raw = {1'b0, l2_reg} + {1'b0, s2_reg} - {1'b0, prod2_reg};
        end
        hi_next = (hi_raw > {1'b0, hsl2rgb_pkg::FX_ONE}) ? hsl2rgb_pkg::FX_ONE
                                                          : hi_raw[FW-1:0];
        two_l   = {l2_reg, 1'b0};
        lo_raw  = (two_l > {1'b0, hi_next}) ? (two_l - {1'b0, hi_next}) : '0;
        lo_next = (lo_raw > {1'b0, hi_next}) ? hi_next : lo_raw[FW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ready[2])
        begin
            hi3_reg   <= hi_next;
            lo3_reg   <= lo_next;
            tr3_reg   <= hsl2rgb_pkg::wrap_unit({1'b0, h2_reg} + {1'b0, hsl2rgb_pkg::FX_THIRD});
            tg3_reg   <= hsl2rgb_pkg::wrap_unit({1'b0, h2_reg});
            tb3_reg   <= hsl2rgb_pkg::wrap_unit({1'b0, h2_reg} + {1'b0, hsl2rgb_pkg::FX_ONE}
                                                - {1'b0, hsl2rgb_pkg::FX_THIRD});
            zero3_reg <= zero2_reg;
            lit3_reg  <= lit2_reg;
        end
    end

    // Stages 4 to 6: one ramp slice per channel.
    assign chan_en.s4 = ready[3];
    assign chan_en.s5 = ready[4];
    assign chan_en.s6 = ready[5];

    hsl2rgb_channel u_red (
        .clk  (clk),
        .en   (chan_en),
        .t    (tr3_reg),
        .hi   (hi3_reg),
        .lo   (lo3_reg),
        .chan (red_byte)
    );

    hsl2rgb_channel u_green (
        .clk  (clk),
        .en   (chan_en),
        .t    (tg3_reg),
        .hi   (hi3_reg),
        .lo   (lo3_reg),
        .chan (green_byte)
    );

    hsl2rgb_channel u_blue (
        .clk  (clk),
        .en   (chan_en),
        .t    (tb3_reg),
        .hi   (hi3_reg),
        .lo   (lo3_reg),
        .chan (blue_byte)
    );

    // Grey bypass travels alongside the channel slices.
    always_ff @(posedge clk)
    begin
        if (ready[3])
        begin
            zero4_reg <= zero3_reg;
            lit4_reg  <= lit3_reg;
        end
        if (ready[4])
        begin
            zero5_reg <= zero4_reg;
            lit5_reg  <= lit4_reg;
        end
        if (ready[5])
        begin
            zero6_reg <= zero5_reg;
            lit6_reg  <= lit5_reg;
        end
    end

    // Output item: zero saturation gives lightness on all three channels.
    assign m_axis_tvalid = valid_reg[5];
    assign m_axis_tdata  = zero6_reg ? {lit6_reg, lit6_reg, lit6_reg}
                                     : {blue_byte, green_byte, red_byte};

    // The input side is never blocked while the output register is empty.
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[5] |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    // The lower bound never exceeds the upper bound.
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (lo3_reg <= hi3_reg))
        else $error("lower bound above upper bound");

    // The upper bound stays within one.
    a_hi_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> (hi3_reg <= hsl2rgb_pkg::FX_ONE))
        else $error("upper bound above one");

    // An item held at the output moves the whole full pipeline nowhere.
    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg == 6'b111111) && !m_axis_tready |=> (valid_reg == 6'b111111))
        else $error("item lost while the receiver stalled");

endmodule
